// ----- rtl/cdq_pkg.sv -----
`default_nettype none

package cdq_pkg;

    // Default geometry of the ring
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_VALUE_BITS = 16;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_INSERT     = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_POP_BACK   = 3'd4;
    localparam logic [2:0] MODE_PEEK       = 3'd5;

    // Status codes of a result
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] value;
    } t_cdq_in;

    typedef struct packed {
        logic [15:0] front_value;
        logic [15:0] back_value;
        logic        is_empty;
        logic        is_full;
        logic [1:0]  status;
    } t_cdq_out;

endpackage

`default_nettype wire

// ----- rtl/circular_deque_with_sorted_insert.sv -----
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | into      | i_in_valid / o_in_stall  | t_cdq_in  (mode, value)
//  out     | out of    | o_out_valid / i_out_stall | t_cdq_out (front, back, flags, status)
//
//  Push, pop and peek results go through S_EXEC and S_READ and load in S_DONE.
//  An ordered insert that is not refused scans in S_SCAN between S_EXEC and S_READ,
//  over the n entries held (n at most SLOTS - 2) and then the free slot past the back;
//  its scan uses at most one compare and one slot-memory write per cycle.
//  One transaction is in work at a time; o_in_stall is high until its result is loaded.
//  A result waits in the output register under i_out_stall while the next input is taken;
//  the next result then waits in S_DONE until the output register is free.
//  Reset (i_rst_n low, synchronous) empties the ring; the slot memory is not cleared.
`default_nettype none

module circular_deque_with_sorted_insert
    import cdq_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_cdq_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_cdq_out      o_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = IW + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        return (i == IW'(SLOTS - 1)) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        return (i == '0) ? IW'(SLOTS - 1) : IW'(i - 1'b1);
    endfunction

    // Slot memory: one write port, two registered read ports
    logic [VALUE_BITS-1:0] r_mem [SLOTS];
    logic [VALUE_BITS-1:0] r_rd_a, r_rd_b;
    logic [IW-1:0]         rd_addr_a, rd_addr_b, mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_we;

    // Control and datapath registers
    logic [2:0]            r_state, n_state;
    logic [IW-1:0]         r_front, n_front;
    logic [IW-1:0]         r_back, n_back;
    logic [2:0]            r_mode, n_mode;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [1:0]            r_status, n_status;
    logic [IW-1:0]         r_ptr, n_ptr;
    logic [IW-1:0]         r_left, n_left;
    logic                  r_found, n_found;
    logic [VALUE_BITS-1:0] r_carry, n_carry;
    logic                  r_out_valid, n_out_valid;
    t_cdq_out              r_out, n_out;

    logic                  in_take;
    logic                  q_empty, q_full;
    logic [IW-1:0]         q_count;

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign q_empty = (r_front == r_back);
    assign q_full  = (ring_next(r_back) == r_front);
    // Entries held: back minus front around the ring
    assign q_count = (r_back >= r_front) ? IW'(r_back - r_front)
                   : IW'(CW'(r_back) + CW'(SLOTS) - CW'(r_front));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_mode      = r_mode;
        n_val       = r_val;
        n_status    = r_status;
        n_ptr       = r_ptr;
        n_left      = r_left;
        n_found     = r_found;
        n_carry     = r_carry;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        // By default, fetch front and back entries for the result
        rd_addr_a   = ring_next(r_front);
        rd_addr_b   = r_back;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = r_val;

        // Retire the held result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_mode   = i_in.mode;
                    n_val    = VALUE_BITS'(i_in.value);
                    n_status = STAT_DONE;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_READ;
                unique case (r_mode)
                    MODE_PUSH_BACK: begin
                        if (q_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = ring_next(r_back);
                            n_back    = ring_next(r_back);
                        end
                    end
                    MODE_PUSH_FRONT: begin
                        if (q_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_front;
                            n_front   = ring_prev(r_front);
                        end
                    end
                    MODE_INSERT: begin
                        if (q_full) begin
                            n_status = STAT_FULL;
                        end else begin
                            // Start the scan at the front entry
                            n_ptr     = ring_next(r_front);
                            n_left    = q_count;
                            n_found   = 1'b0;
                            rd_addr_a = ring_next(r_front);
                            n_state   = S_SCAN;
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (q_empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_front = ring_next(r_front);
                        end
                    end
                    MODE_POP_BACK: begin
                        if (q_empty) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_back = ring_prev(r_back);
                        end
                    end
                    default: begin
                        // Peek and unused codes leave the ring as is
                    end
                endcase
            end

            S_SCAN: begin
                // r_rd_a holds the entry at r_ptr; prefetch the next slot
                rd_addr_a = ring_next(r_ptr);
                mem_waddr = r_ptr;
                if (r_left == '0) begin
                    // Free slot past the back: place the value or the last carry
                    mem_we    = 1'b1;
                    mem_wdata = r_found ? r_carry : r_val;
                    n_back    = ring_next(r_back);
                    n_state   = S_READ;
                end else begin
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_carry;
                        n_carry   = r_rd_a;
                    end else if (r_rd_a <= r_val) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_val;
                        n_found   = 1'b1;
                        n_carry   = r_rd_a;
                    end
                    n_ptr  = ring_next(r_ptr);
                    n_left = IW'(r_left - 1'b1);
                end
            end

            S_READ: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                // Load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.front_value = q_empty ? 16'd0 : 16'(r_rd_a);
                    n_out.back_value  = q_empty ? 16'd0 : 16'(r_rd_b);
                    n_out.is_empty    = q_empty;
                    n_out.is_full     = q_full;
                    n_out.status      = r_status;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= IW'(SLOTS - 1);
            r_back      <= IW'(SLOTS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_status <= n_status;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_found  <= n_found;
        r_carry  <= n_carry;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/cdq_checker.sv -----
`default_nettype none

module cdq_checker
    import cdq_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     i_in_stall,
    input wire logic     i_out_valid,
    input wire logic     i_out_stall,
    input wire t_cdq_out i_out
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("stalled result changed or dropped");

    // Take one transaction at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken while a transaction is in work");

    // Report zero values and not full on an empty ring
    a_empty_vals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.is_empty |->
            i_out.front_value == 16'd0 && i_out.back_value == 16'd0 && !i_out.is_full)
        else $error("empty ring with nonzero values or full flag");

    // Refusals agree with the flags
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out.status == STAT_DONE)
            || (i_out.status == STAT_FULL && i_out.is_full)
            || (i_out.status == STAT_EMPTY && i_out.is_empty))
        else $error("status disagrees with ring flags");

endmodule

bind circular_deque_with_sorted_insert cdq_checker u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

`default_nettype wire

// ----- tb/sv/circular_deque_with_sorted_insert_test.sv -----
`timescale 1ns / 100ps

module circular_deque_with_sorted_insert_test;
    import cdq_pkg::*;

    localparam int RING = DEF_SLOTS;

    // Mode codes the block does not define; it must treat them as a peek
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    // Results that can be written down without running the ring
    localparam t_cdq_out RES_EMPTY_DONE    = {16'h0000, 16'h0000, 1'b1, 1'b0, STAT_DONE};
    localparam t_cdq_out RES_EMPTY_REFUSED = {16'h0000, 16'h0000, 1'b1, 1'b0, STAT_EMPTY};
    localparam t_cdq_out RES_NONE          = '0;

    // One directed row: the operation and, where obvious, its typed-in result
    typedef struct packed {
        t_cdq_in  op;
        logic     has_fixed;
        t_cdq_out fixed;
    } t_stim_row;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    t_cdq_in  in_data   = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_cdq_out o_out;

    // Predicted ring contents and markers
    logic [15:0] ring_slot [RING];
    int          head_mark = RING - 1;
    int          tail_mark = RING - 1;

    // Deque views still owed by the block, oldest first
    t_cdq_out deque_snapshots [$];
    int       fail_count = 0;

    // Sender burst bookkeeping
    int burst_left = 0;

    circular_deque_with_sorted_insert DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("circular_deque_with_sorted_insert_test: done, errors");
        $finish;
    end

    function automatic int ring_next(int i);
        return (i + 1) % RING;
    endfunction

    function automatic int ring_prev(int i);
        return (i + RING - 1) % RING;
    endfunction

    // Apply one operation to the predicted ring and return the view afterwards
    function automatic t_cdq_out apply_deque_op(t_cdq_in op);
        t_cdq_out view;
        logic     was_full;
        logic     was_empty;
        int       held;
        int       pos;
        logic [1:0] stat;
        was_full  = (ring_next(tail_mark) == head_mark);
        was_empty = (head_mark == tail_mark);
        stat      = STAT_DONE;
        case (op.mode)
            MODE_PUSH_BACK: begin
                if (was_full) begin
                    stat = STAT_FULL;
                end else begin
                    tail_mark = ring_next(tail_mark);
                    ring_slot[tail_mark] = op.value;
                end
            end
            MODE_PUSH_FRONT: begin
                if (was_full) begin
                    stat = STAT_FULL;
                end else begin
                    ring_slot[head_mark] = op.value;
                    head_mark = ring_prev(head_mark);
                end
            end
            MODE_INSERT: begin
                if (was_full) begin
                    stat = STAT_FULL;
                end else begin
                    // Land in front of the first entry that is not larger
                    held = (tail_mark + RING - head_mark) % RING;
                    pos  = held;
                    for (int k = 0; k < held; k++) begin
                        if (ring_slot[(head_mark + 1 + k) % RING] <= op.value) begin
                            pos = k;
                            break;
                        end
                    end
                    for (int k = held; k > pos; k--) begin
                        ring_slot[(head_mark + 1 + k) % RING] =
                            ring_slot[(head_mark + k) % RING];
                    end
                    ring_slot[(head_mark + 1 + pos) % RING] = op.value;
                    tail_mark = ring_next(tail_mark);
                end
            end
            MODE_POP_FRONT: begin
                if (was_empty) stat = STAT_EMPTY;
                else head_mark = ring_next(head_mark);
            end
            MODE_POP_BACK: begin
                if (was_empty) stat = STAT_EMPTY;
                else tail_mark = ring_prev(tail_mark);
            end
            default: begin
            end
        endcase
        if (head_mark == tail_mark) begin
            view.front_value = 16'h0000;
            view.back_value  = 16'h0000;
            view.is_empty    = 1'b1;
        end else begin
            view.front_value = ring_slot[ring_next(head_mark)];
            view.back_value  = ring_slot[tail_mark];
            view.is_empty    = 1'b0;
        end
        view.is_full = (ring_next(tail_mark) == head_mark);
        view.status  = stat;
        return view;
    endfunction

    // Offer one transaction, idling between bursts; return at the accepting edge
    task automatic drive_op(t_cdq_in op);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_data  <= op;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    // Receiver: check every accepted result, then pick the stall for the next cycle
    initial begin : receiver
        t_cdq_out want;
        int rx_cycles;
        int hold_left;
        int style;
        int style_left;
        int period;
        int duty;
        rx_cycles  = 0;
        hold_left  = 0;
        style      = 0;
        style_left = 0;
        period     = 4;
        duty       = 1;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (o_out_valid === 1'b1 && !out_stall) begin
                if (deque_snapshots.size() == 0) begin
                    $error("result with nothing expected: %h", o_out);
                    fail_count++;
                end else begin
                    want = deque_snapshots.pop_front();
                    if (o_out.front_value !== want.front_value) begin
                        $error("front_value: expected %h, actual %h",
                               want.front_value, o_out.front_value);
                        fail_count++;
                    end
                    if (o_out.back_value !== want.back_value) begin
                        $error("back_value: expected %h, actual %h",
                               want.back_value, o_out.back_value);
                        fail_count++;
                    end
                    if (o_out.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %b, actual %b",
                               want.is_empty, o_out.is_empty);
                        fail_count++;
                    end
                    if (o_out.is_full !== want.is_full) begin
                        $error("is_full: expected %b, actual %b",
                               want.is_full, o_out.is_full);
                        fail_count++;
                    end
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_out.status);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                // Long hold-off: back the block up until it stalls its input
                hold_left--;
                out_stall <= 1'b1;
            end else if (rx_cycles % 15000 == 2000) begin
                hold_left = 400;
                out_stall <= 1'b1;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(64, 256);
                    period     = $urandom_range(2, 7);
                    duty       = $urandom_range(1, period - 1);
                end
                style_left--;
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ((rx_cycles % period) < duty);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_stim_row rows [$];
        t_cdq_in   op;
        t_cdq_out  predicted;
        int        bias;
        int        block_left;
        int        push_pct;
        int        pick;
        int        r;
        int        waited;

        // Empty ring: peeks, refused pops, undefined modes, then a first insert and push to the front
        rows.push_back({MODE_PEEK,       16'h0000, 1'b1, RES_EMPTY_DONE});
        rows.push_back({MODE_POP_FRONT,  16'h0000, 1'b1, RES_EMPTY_REFUSED});
        rows.push_back({MODE_POP_BACK,   16'hFFFF, 1'b1, RES_EMPTY_REFUSED});
        rows.push_back({MODE_UNUSED_6,   16'hFFFF, 1'b1, RES_EMPTY_DONE});
        rows.push_back({MODE_UNUSED_7,   16'h0000, 1'b1, RES_EMPTY_DONE});
        rows.push_back({MODE_INSERT,     16'h0000, 1'b1,
                        {16'h0000, 16'h0000, 1'b0, 1'b0, STAT_DONE}});
        rows.push_back({MODE_PUSH_FRONT, 16'hFFFF, 1'b1,
                        {16'hFFFF, 16'h0000, 1'b0, 1'b0, STAT_DONE}});
        // Contents now unsorted; insert still lands before the first entry not larger
        rows.push_back({MODE_PUSH_BACK,  16'hFFFF, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h8000, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'hFFFF, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h0001, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_BACK,  16'h5555, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_FRONT, 16'hAAAA, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h1234, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_BACK,  16'h0000, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_FRONT, 16'h0001, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h7FFF, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h0000, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_BACK,  16'hFFFE, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h8001, 1'b0, RES_NONE});
        // Full ring: every kind of push is refused, then pops from both ends and a peek
        rows.push_back({MODE_PUSH_BACK,  16'h1111, 1'b0, RES_NONE});
        rows.push_back({MODE_PUSH_FRONT, 16'h2222, 1'b0, RES_NONE});
        rows.push_back({MODE_INSERT,     16'h3333, 1'b0, RES_NONE});
        rows.push_back({MODE_POP_BACK,   16'h0000, 1'b0, RES_NONE});
        rows.push_back({MODE_POP_FRONT,  16'h0000, 1'b0, RES_NONE});
        rows.push_back({MODE_PEEK,       16'hFFFF, 1'b0, RES_NONE});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            drive_op(rows[i].op);
            predicted = apply_deque_op(rows[i].op);
            deque_snapshots.push_back(rows[i].has_fixed ? rows[i].fixed : predicted);
        end

        // Random part: blocks that lean toward filling, draining, balance or sorting
        block_left = 0;
        bias       = 0;
        for (int n = 0; n < 1050; n++) begin
            if (block_left == 0) begin
                bias       = $urandom_range(0, 3);
                block_left = $urandom_range(20, 60);
            end
            block_left--;
            case (bias)
                0: push_pct = 75;
                1: push_pct = 25;
                2: push_pct = 50;
                default: push_pct = 60;
            endcase
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, 9);
            if (pick < 5) begin
                op.mode = (r < 6) ? MODE_PEEK : ((r < 8) ? MODE_UNUSED_6 : MODE_UNUSED_7);
            end else if (pick < push_pct) begin
                if (bias == 3)
                    op.mode = (r < 7) ? MODE_INSERT
                                      : ((r < 9) ? MODE_PUSH_BACK : MODE_PUSH_FRONT);
                else
                    op.mode = (r < 3) ? MODE_PUSH_BACK
                                      : ((r < 6) ? MODE_PUSH_FRONT : MODE_INSERT);
            end else begin
                op.mode = (r < 5) ? MODE_POP_FRONT : MODE_POP_BACK;
            end
            r = $urandom_range(0, 7);
            case (r)
                0: op.value = 16'h0000;
                1: op.value = 16'hFFFF;
                2, 3: op.value = 16'($urandom_range(0, 7));
                default: op.value = 16'($urandom());
            endcase
            drive_op(op);
            predicted = apply_deque_op(op);
            deque_snapshots.push_back(predicted);
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then a little longer for strays
        waited = 0;
        while (deque_snapshots.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (deque_snapshots.size() != 0) begin
            $error("%0d expected results never arrived", deque_snapshots.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("circular_deque_with_sorted_insert_test: done, clean");
        end else begin
            $display("circular_deque_with_sorted_insert_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- circular_deque_with_sorted_insert.f -----
rtl/cdq_pkg.sv
rtl/circular_deque_with_sorted_insert.sv
rtl/cdq_checker.sv
tb/sv/circular_deque_with_sorted_insert_test.sv
